// ===== hw/rtl/stc_pkg.sv =====
package stc_pkg;

    localparam int unsigned DIV_MIN    = 20;
    localparam int unsigned DIV_SPAN   = 43;
    localparam int unsigned DIV_MAX    = DIV_MIN + DIV_SPAN - 1;
    localparam int unsigned ALPHA_SIZE = 64;
    localparam int unsigned IDX_W      = $clog2(ALPHA_SIZE);
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned QUO_W      = 4;
    localparam int unsigned DIV_STEPS  = QUO_W;

    // Operation codes carried in the operation field of an input word.
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef logic [IDX_W-1:0]  sym_idx_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // The 64 symbol characters, in index order.
    localparam byte_t ALPHABET [ALPHA_SIZE] = '{
        8'h43, 8'h36, 8'h64, 8'h37, 8'h44, 8'h38, 8'h65, 8'h39, 8'h45, 8'h68, 8'h66, 8'h48, 8'h46,
        8'h30, 8'h61, 8'h31, 8'h41, 8'h32, 8'h62, 8'h33, 8'h42, 8'h34, 8'h63, 8'h35, 8'h75, 8'h55,
        8'h67, 8'h47, 8'h73, 8'h53, 8'h69, 8'h49, 8'h6F, 8'h4F, 8'h70, 8'h50, 8'h77, 8'h57, 8'h6A,
        8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h3D,
        8'h7B, 8'h7D, 8'h7C, 8'h5C, 8'h2F, 8'h2C, 8'h2E, 8'h3E, 8'h3C, 8'h3F, 8'h22, 8'h27
    };

    typedef struct packed {
        logic     hit;
        sym_idx_t idx;
    } sym_match_t;

    typedef enum logic [1:0] {
        SEL_DIV,
        SEL_QUO,
        SEL_REM,
        SEL_BYTE
    } out_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     div_step;
        logic     lookup;
        logic     out_load;
        out_sel_t out_sel;
    } stc_cmd_t;

    typedef struct packed {
        logic grp_last;
        logic out_free;
    } stc_status_t;

    // Reverse lookup: each entry is compared on its own, the characters are distinct.
    function automatic sym_match_t symbol_index(input byte_t ch);
        sym_match_t m;
        m.hit = 1'b0;
        m.idx = '0;
        for (int k = 0; k < ALPHA_SIZE; k++) begin
            if (ALPHABET[sym_idx_t'(k)] == ch) begin
                m.hit = 1'b1;
                m.idx = sym_idx_t'(k);
            end
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/stc_if.sv =====
interface stc_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;
    logic [5:0] divisor;

    modport source (output valid, output operation, output data_byte, output divisor,
                    input ready);
    modport sink   (input valid, input operation, input data_byte, input divisor,
                    output ready);
endinterface

interface stc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== hw/rtl/stc_ctrl.sv =====
module stc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_operation,
    output logic                in_ready,
    input  stc_pkg::stc_status_t status,
    output stc_pkg::stc_cmd_t   cmd
);
    import stc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DIV    = 7'b0000010,
        S_EMIT_D = 7'b0000100,
        S_EMIT_Q = 7'b0001000,
        S_EMIT_R = 7'b0010000,
        S_LOOKUP = 7'b0100000,
        S_EMIT_B = 7'b1000000
    } state_t;

    localparam int unsigned CNT_W = $clog2(DIV_STEPS);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        in_ready     = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.div_step = 1'b0;
        cmd.lookup   = 1'b0;
        cmd.out_load = 1'b0;
        cmd.out_sel  = SEL_DIV;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    cnt_next    = '0;
                    state_next  = (in_operation == OP_DECODE) ? S_LOOKUP : S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_EMIT_D;
                end
            end
            S_EMIT_D: begin
                cmd.out_sel = SEL_DIV;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_EMIT_Q;
                end
            end
            S_EMIT_Q: begin
                cmd.out_sel = SEL_QUO;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_EMIT_R;
                end
            end
            S_EMIT_R: begin
                cmd.out_sel = SEL_REM;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = status.grp_last ? S_EMIT_B : S_IDLE;
            end
            S_EMIT_B: begin
                cmd.out_sel = SEL_BYTE;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/stc_datapath.sv =====
module stc_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  stc_pkg::byte_t      in_data_byte,
    input  logic [5:0]          in_divisor,
    input  stc_pkg::stc_cmd_t   cmd,
    output stc_pkg::stc_status_t status,
    input  logic                out_ready,
    output logic                out_valid,
    output stc_pkg::byte_t      out_byte,
    output logic                out_last
);
    import stc_pkg::*;

    localparam int unsigned SDIV_W = BYTE_W + 1;

    // Encode divider and decode character share the work register.
    byte_t                work_reg;
    sym_idx_t             div_reg;
    logic [SDIV_W-1:0]    sdiv_reg;
    logic [QUO_W-1:0]     quo_reg;

    logic [1:0]           pos_reg;
    sym_idx_t             held_d_reg, held_q_reg, held_r_reg;

    logic                 out_valid_reg;
    byte_t                out_byte_reg;
    logic                 out_last_reg;

    sym_idx_t             div_clamped;
    logic                 fits;
    sym_match_t           match;
    logic [2*IDX_W-1:0]   product;
    byte_t                plain;
    byte_t                out_byte_next;

    always_comb begin
        if (in_divisor < IDX_W'(DIV_MIN)) begin
            div_clamped = IDX_W'(DIV_MIN);
        end else if (in_divisor > IDX_W'(DIV_MAX)) begin
            div_clamped = IDX_W'(DIV_MAX);
        end else begin
            div_clamped = in_divisor;
        end
    end

    assign fits    = {1'b0, work_reg} >= sdiv_reg;
    assign match   = symbol_index(work_reg);
    assign product = {{IDX_W{1'b0}}, held_q_reg} * {{IDX_W{1'b0}}, held_d_reg};
    assign plain   = product[BYTE_W-1:0] + BYTE_W'(held_r_reg);

    // Restoring division, one quotient bit per step from the top.
    always_ff @(posedge clk) begin
        if (cmd.load_in) begin
            work_reg <= in_data_byte;
            div_reg  <= div_clamped;
            sdiv_reg <= SDIV_W'(div_clamped) << (QUO_W - 1);
            quo_reg  <= '0;
        end else if (cmd.div_step) begin
            if (fits) begin
                work_reg <= work_reg - sdiv_reg[BYTE_W-1:0];
            end
            sdiv_reg <= sdiv_reg >> 1;
            quo_reg  <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign status.grp_last = pos_reg[1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg    <= '0;
            held_d_reg <= '0;
            held_q_reg <= '0;
            held_r_reg <= '0;
        end else if (cmd.lookup) begin
            if (pos_reg == 2'd0) begin
                if (match.hit) begin
                    held_d_reg <= match.idx;
                end
                pos_reg <= 2'd1;
            end else if (pos_reg == 2'd1) begin
                if (match.hit) begin
                    held_q_reg <= match.idx;
                end
                pos_reg <= 2'd2;
            end else begin
                if (match.hit) begin
                    held_r_reg <= match.idx;
                end
                pos_reg <= 2'd0;
            end
        end
    end

    always_comb begin
        unique case (cmd.out_sel)
            SEL_DIV:  out_byte_next = ALPHABET[div_reg];
            SEL_QUO:  out_byte_next = ALPHABET[IDX_W'(quo_reg)];
            SEL_REM:  out_byte_next = ALPHABET[work_reg[IDX_W-1:0]];
            SEL_BYTE: out_byte_next = plain;
            default:  out_byte_next = '0;
        endcase
    end

    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.out_load) begin
            out_byte_reg <= out_byte_next;
            out_last_reg <= (cmd.out_sel == SEL_REM) || (cmd.out_sel == SEL_BYTE);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hw/rtl/symbol_triple_codec.sv =====
// Channel   Direction  Word contents
// in_word   sink       operation, data_byte, divisor
// out_word  source     out_byte, last
//
// An encode word is accepted, then takes four steps in the shared restoring divider (one
// quotient bit per cycle) and then emits its three symbols, each of which the output can stall.
// A decode word is accepted and looked up; the character that completes a group also emits a byte.
// Reset clears the control state, the decode group position and the held indices.
// A stalled output holds the controller in its emit state; the last result of a word may
// wait in the output register while the next input word is already accepted.
module symbol_triple_codec (
    input  logic      clk,
    input  logic      rst_n,
    stc_in_if.sink    in_word,
    stc_out_if.source out_word
);
    import stc_pkg::*;

    stc_cmd_t    cmd;
    stc_status_t status;

    // The controller sequences the divider steps, the decode lookup and the result words.
    stc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_word.valid),
        .in_operation (in_word.operation),
        .in_ready     (in_word.ready),
        .status       (status),
        .cmd          (cmd)
    );

    // The datapath holds the divider, the decode group state and the output register.
    stc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_data_byte (in_word.data_byte),
        .in_divisor   (in_word.divisor),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (out_word.ready),
        .out_valid    (out_word.valid),
        .out_byte     (out_word.out_byte),
        .out_last     (out_word.last)
    );

endmodule
